// ===== rtl/sha256rr_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256rr_pkg
// Operation codes, stream widths and the SHA-256 round constant table shared
// by the resumable round engine.
// ----------------------------------------------------------------------------
package sha256rr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_CHAIN = 2'd0,
    OP_LOAD_WORK  = 2'd1,
    OP_ROUND      = 2'd2,
    OP_FINISH     = 2'd3
  } op_e;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned NWORDS   = 8;
  localparam int unsigned ROUND_W  = 7;
  localparam int unsigned TDATA_W  = 40;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/sha256_resumable_rounds.sv =====
// ----------------------------------------------------------------------------
// sha256_resumable_rounds
// SHA-256 compression rounds with loadable chaining and working state.
//
// The slave stream carries one operation per transaction: tuser holds the
// operation, tdata the word index and the word. Loads write one chaining or
// working word and rearm the round counter from the first-round register.
// A round transaction runs one SHA-256 round with the supplied schedule word
// and is ignored once the counter has reached 64. Every operation takes
// effect at the edge it is accepted, so one transaction per cycle is taken.
// A finish adds the working words into the chaining words in that same cycle
// and captures the eight sums in an output shift register; they leave on the
// master stream one per cycle from the next cycle on, index 0 first, with
// tlast on index 7. While that burst is pending, loads and rounds are still
// taken; a new finish waits until the last word of the burst is taken, so a
// stalled receiver holds only finish transactions. Reset clears the chaining
// and working words, counter and first-round register and empties the output.
// ----------------------------------------------------------------------------
module sha256_resumable_rounds
  import sha256rr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ROUND_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: word_index[2:0], word_value[34:3], zero padding[39:35]
  input  logic [TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: result_index[2:0], result_value[34:3], zero padding[39:35]
  output logic [TDATA_W-1:0]  m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  logic [ROUND_W-1:0] first_round_q;
  logic [ROUND_W-1:0] round_cnt_q, round_cnt_d;
  word_t              chain_q [NWORDS];
  word_t              chain_d [NWORDS];
  word_t              work_q  [NWORDS];
  word_t              work_d  [NWORDS];
  word_t              out_buf_q [NWORDS];
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_valid_q;

  logic               in_acc;
  logic               out_take;
  logic               out_last;
  logic [1:0]         op;
  logic [IDX_W-1:0]   in_idx;
  word_t              in_val;
  word_t              sum_words [NWORDS];
  word_t              big0, big1, chs, maj, t1, t2;

  assign op     = s_axis_tuser_i;
  assign in_idx = s_axis_tdata_i[IDX_W-1:0];
  assign in_val = s_axis_tdata_i[IDX_W+WORD_W-1:IDX_W];

  assign out_last = (out_idx_q == IDX_W'(NWORDS-1));
  assign out_take = out_valid_q && m_axis_tready_i;

  assign s_axis_tready_o = !out_valid_q || (op != OP_FINISH) || (out_take && out_last);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = {(TDATA_W-IDX_W-WORD_W)'(0), out_buf_q[0], out_idx_q};

  always_comb begin
    big0 = {work_q[0][1:0],  work_q[0][31:2]}  ^ {work_q[0][12:0], work_q[0][31:13]} ^
           {work_q[0][21:0], work_q[0][31:22]};
    big1 = {work_q[4][5:0],  work_q[4][31:6]}  ^ {work_q[4][10:0], work_q[4][31:11]} ^
           {work_q[4][24:0], work_q[4][31:25]};
    chs  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1   = work_q[7] + big1 + chs + K_TABLE[round_cnt_q[5:0]] + in_val;
    t2   = big0 + maj;
  end

  always_comb begin
    for (int i = 0; i < NWORDS; i++) begin
      sum_words[i] = chain_q[i] + work_q[i];
    end
  end

  always_comb begin
    chain_d     = chain_q;
    work_d      = work_q;
    round_cnt_d = round_cnt_q;
    if (in_acc) begin
      case (op)
        OP_LOAD_CHAIN: begin
          chain_d[in_idx] = in_val;
          round_cnt_d     = first_round_q;
        end
        OP_LOAD_WORK: begin
          work_d[in_idx] = in_val;
          round_cnt_d    = first_round_q;
        end
        OP_ROUND: begin
          if (!round_cnt_q[ROUND_W-1]) begin
            work_d[7]   = work_q[6];
            work_d[6]   = work_q[5];
            work_d[5]   = work_q[4];
            work_d[4]   = work_q[3] + t1;
            work_d[3]   = work_q[2];
            work_d[2]   = work_q[1];
            work_d[1]   = work_q[0];
            work_d[0]   = t1 + t2;
            round_cnt_d = round_cnt_q + ROUND_W'(1);
          end
        end
        default: begin
          chain_d = sum_words;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_round_q <= '0;
      round_cnt_q   <= '0;
      for (int i = 0; i < NWORDS; i++) begin
        chain_q[i] <= '0;
        work_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        first_round_q <= cfg_wdata_i;
      end
      round_cnt_q <= round_cnt_d;
      chain_q     <= chain_d;
      work_q      <= work_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else if (in_acc && op == OP_FINISH) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= '0;
    end else if (out_take) begin
      out_valid_q <= !out_last;
      out_idx_q   <= out_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op == OP_FINISH) begin
      out_buf_q <= sum_words;
    end else if (out_take) begin
      for (int i = 0; i < NWORDS - 1; i++) begin
        out_buf_q[i] <= out_buf_q[i+1];
      end
    end
  end

  a_finish_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_FINISH) |=> (out_valid_q && out_idx_q == '0))
    else $error("finish did not start an output burst at index 0");

  a_burst_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_last && !(in_acc && op == OP_FINISH)) |=>
      (out_valid_q && out_idx_q == $past(out_idx_q) + IDX_W'(1)))
    else $error("output burst did not advance by one word");

  a_round_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_ROUND && !round_cnt_q[ROUND_W-1]) |=>
      (round_cnt_q == $past(round_cnt_q) + ROUND_W'(1)))
    else $error("round counter did not advance on an active round");

  a_spent_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_ROUND && round_cnt_q[ROUND_W-1]) |=>
      ($stable(round_cnt_q) && $stable(work_q[0]) && $stable(work_q[4])))
    else $error("round past the end changed state");

  a_finish_keeps_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_FINISH) |=> ($stable(round_cnt_q) && $stable(work_q[0])))
    else $error("finish changed the working state");

endmodule

// ===== verif/tb_sha256_resumable_rounds.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_resumable_rounds
// Self-checking testbench for the resumable SHA-256 round engine. It drives
// loads, rounds and finishes on the slave stream, keeps its own model of the
// chaining words, working words and round counter, and checks every word of
// each finish burst on the master stream against the model. Directed tests
// cover reset state, word wraparound, the last round and ignored rounds and
// the first-round register; random load/round/finish sequences follow under
// several register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_sha256_resumable_rounds;
  import sha256rr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAST_ROUND  = 64;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned ITEM_BUDGET = 460;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    word_t            value;
    logic             last;
  } chain_sum_t;

  typedef enum int {
    RX_READY,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [ROUND_W-1:0]  cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata_o;
  logic                m_axis_tlast_o;

  word_t              chain_q [NWORDS];
  word_t              work_q [NWORDS];
  logic [ROUND_W-1:0] round_ctr_q;
  logic [ROUND_W-1:0] first_round_q;

  chain_sum_t pending_sums [$];
  int         errors;
  int         items_done;
  int         burst_left;
  int         stuck_cycles;
  rx_mode_e   rx_mode;
  int         rx_left;

  sha256_resumable_rounds dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic word_t rotr(word_t v, int unsigned s);
    return (v >> s) | (v << (WORD_W - s));
  endfunction

  task automatic compress_round(word_t w, word_t k);
    word_t a, e, t1, t2, ch, mj;
    a  = work_q[0];
    e  = work_q[4];
    ch = (e & work_q[5]) ^ (~e & work_q[6]);
    mj = (a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1 = work_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
    work_q[7] = work_q[6];
    work_q[6] = work_q[5];
    work_q[5] = e;
    work_q[4] = work_q[3] + t1;
    work_q[3] = work_q[2];
    work_q[2] = work_q[1];
    work_q[1] = a;
    work_q[0] = t1 + t2;
  endtask

  task automatic apply_op(op_e op, logic [IDX_W-1:0] idx, word_t val);
    chain_sum_t sum;
    case (op)
      OP_LOAD_CHAIN: begin
        chain_q[idx] = val;
        round_ctr_q = first_round_q;
      end
      OP_LOAD_WORK: begin
        work_q[idx] = val;
        round_ctr_q = first_round_q;
      end
      OP_ROUND: begin
        if (round_ctr_q < LAST_ROUND) begin
          compress_round(val, K_TABLE[round_ctr_q[5:0]]);
          round_ctr_q = round_ctr_q + 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < NWORDS; i++) begin
          chain_q[i] = chain_q[i] + work_q[i];
          sum.index = i[IDX_W-1:0];
          sum.value = chain_q[i];
          sum.last = (i == NWORDS - 1);
          pending_sums = {pending_sums, sum};
        end
      end
    endcase
    items_done++;
  endtask

  task automatic send_op(op_e op, logic [IDX_W-1:0] idx, word_t val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {{(TDATA_W - WORD_W - IDX_W){1'b0}}, val, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_op(op, idx, val);
    burst_left--;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_first_round(logic [ROUND_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    first_round_q = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    return IDX_W'($urandom_range(0, NWORDS - 1));
  endfunction

  task automatic test_reset_finish();
    send_op(OP_FINISH, 3'd7, 32'hffff_ffff);
  endtask

  task automatic test_word_wraparound();
    send_op(OP_LOAD_CHAIN, 3'd0, 32'hffff_ffff);
    send_op(OP_LOAD_CHAIN, 3'd7, 32'h8000_0000);
    send_op(OP_LOAD_WORK, 3'd0, 32'h0000_0001);
    send_op(OP_LOAD_WORK, 3'd7, 32'h8000_0000);
    send_op(OP_FINISH, 3'd0, 32'h0000_0000);
    send_op(OP_FINISH, 3'd5, 32'h5a5a_a5a5);
  endtask

  task automatic test_last_round();
    wait_idle();
    write_first_round(7'd63);
    send_op(OP_LOAD_WORK, 3'd4, 32'hffff_ffff);
    send_op(OP_ROUND, 3'd2, 32'hffff_ffff);
    send_op(OP_ROUND, 3'd6, 32'h1234_5678);
    send_op(OP_FINISH, 3'd1, 32'h0);
  endtask

  task automatic test_register_no_rearm();
    wait_idle();
    write_first_round(7'd0);
    send_op(OP_LOAD_WORK, 3'd0, 32'h0);
    send_op(OP_ROUND, 3'd3, 32'h0);
    send_op(OP_ROUND, 3'd4, 32'hffff_ffff);
    wait_idle();
    write_first_round(7'd64);
    send_op(OP_ROUND, 3'd0, 32'ha5a5_a5a5);
    send_op(OP_FINISH, 3'd2, 32'h0);
    send_op(OP_LOAD_CHAIN, 3'd1, 32'h0);
    send_op(OP_ROUND, 3'd7, 32'h0f0f_0f0f);
    send_op(OP_FINISH, 3'd6, 32'hffff_ffff);
  endtask

  task automatic random_block();
    int n_chain, n_work, n_rounds;
    n_chain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : NWORDS;
    n_work = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : NWORDS;
    for (int i = 0; i < n_chain; i++)
      send_op(OP_LOAD_CHAIN, pick_index(), pick_word());
    for (int i = 0; i < n_work; i++)
      send_op(OP_LOAD_WORK, pick_index(), pick_word());
    n_rounds = $urandom_range(0, 70 - first_round_q);
    for (int i = 0; i < n_rounds; i++)
      send_op(OP_ROUND, pick_index(), pick_word());
    send_op(OP_FINISH, pick_index(), $urandom());
    if ($urandom_range(0, 4) == 0)
      send_op(OP_FINISH, pick_index(), $urandom());
  endtask

  task automatic test_random_sequences();
    logic [ROUND_W-1:0] settings [9];
    int                 goal;
    settings = '{7'd0, 7'd64, 7'd1, 7'd63, 7'd32, 7'd58, 7'd0, 7'd50, 7'd0};
    settings[8] = ROUND_W'($urandom_range(0, LAST_ROUND));
    items_done = 0;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_first_round(settings[p]);
      goal = (p + 1) * ITEM_BUDGET / 9;
      while (items_done < goal) begin
        case ($urandom_range(0, 9))
          0: send_op(op_e'($urandom_range(0, 3)), pick_index(), $urandom());
          1: wait_idle();
          default: random_block();
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(1, 30);
    end
    rx_left--;
    case (rx_mode)
      RX_READY:  m_axis_tready_i <= 1'b1;
      RX_RANDOM: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default:   m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_sums
    chain_sum_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected word index %0d value %h last %b", $time,
                 m_axis_tdata_o[2:0], m_axis_tdata_o[34:3], m_axis_tlast_o);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata_o[2:0] !== want.index) begin
          $display("%0t: index expected %0d actual %0d", $time, want.index,
                   m_axis_tdata_o[2:0]);
          errors++;
        end
        if (m_axis_tdata_o[34:3] !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value,
                   m_axis_tdata_o[34:3]);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last,
                   m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    items_done = 0;
    burst_left = 0;
    stuck_cycles = 0;
    rx_left = 0;
    round_ctr_q = '0;
    first_round_q = '0;
    for (int i = 0; i < NWORDS; i++) begin
      chain_q[i] = '0;
      work_q[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_finish();
    test_word_wraparound();
    test_last_round();
    test_register_no_rearm();
    test_random_sequences();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sha256rr_pkg.sv
rtl/sha256_resumable_rounds.sv
verif/tb_sha256_resumable_rounds.sv
